// File: rtl/pfm_pkg.sv
// package for the paged frame manager: transaction structs, status codes
// no dependencies
package pfm_pkg;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_NO_HDL  = 3'd1;
	localparam logic [2:0] ST_BAD_HDL = 3'd2;
	localparam logic [2:0] ST_RANGE   = 3'd3;
	localparam logic [2:0] ST_TOO_BIG = 3'd4;

	localparam int STAMP_W = 48;

	typedef struct packed {
		logic        cmd;
		logic [24:0] amount;
		logic [3:0]  handle_in;
		logic [23:0] byte_index;
		logic        mark_dirty;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [3:0]  handle_out;
		logic [5:0]  frame;
		logic [19:0] offset;
		logic        fetch;
		logic        write_back;
		logic [3:0]  evict_handle;
		logic [3:0]  evict_page;
		logic        last;
	} rsp_t;

	// scan control between sequencer and victim scanner
	typedef struct packed {
		logic start;
	} scan_ctl_t;

endpackage

// File: rtl/paged_frame_manager_lru.sv
// top level of the paged frame manager: sequencer, frame and map tables
// depends on pfm_pkg and pfm_scan
//
// channel | signals            | direction | handshake
// request | start, busy, req   | in        | taken when start && !busy
// result  | rsp_valid, rsp     | out       | one cycle strobe, no stall
//
// an error result ends the transaction at decode; a hit access looks up the map, then restamps
// a miss fills an unused frame, or, with every frame used, runs the victim scan and evicts first
// allocate claims a frame per page, on an unused frame or on a victim when the scan runs
// the victim scan reads the stamp memory one frame per cycle
// reset clears valid bits, handle table and stamp counter at once
// the receiver cannot stall; busy stays high until the last result
module paged_frame_manager_lru #(
	parameter int FRAMES = 64,
	parameter int HANDLES = 16,
	parameter int PAGES_PER_HANDLE = 16,
	parameter int PAGE_BITS = 20
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  pfm_pkg::req_t req,
	output logic rsp_valid,
	output pfm_pkg::rsp_t rsp
);
	import pfm_pkg::*;
	localparam int FW = $clog2(FRAMES);
	localparam int HW = (HANDLES > 1) ? $clog2(HANDLES) : 1;
	localparam int PW = (PAGES_PER_HANDLE > 1) ? $clog2(PAGES_PER_HANDLE) : 1;
	localparam int CW = $clog2(PAGES_PER_HANDLE + 1);
	localparam int MAP = HANDLES * PAGES_PER_HANDLE;
	localparam int MW = $clog2(MAP) > 0 ? $clog2(MAP) : 1;
	localparam int PGW = 24 - PAGE_BITS + 1;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DEC  = 3'd1;
	localparam logic [2:0] S_MAP  = 3'd2;
	localparam logic [2:0] S_FREE = 3'd3;
	localparam logic [2:0] S_SCAN = 3'd4;
	localparam logic [2:0] S_EVIC = 3'd5;
	localparam logic [2:0] S_FILL = 3'd6;

	// pack one result transaction
	function automatic rsp_t mk_rsp(input logic [2:0] st, input logic [3:0] h,
			input logic [5:0] fr, input logic [19:0] off, input logic fe,
			input logic wb, input logic [3:0] eh, input logic [3:0] ep,
			input logic lst);
		rsp_t r;
		r.status = st;
		r.handle_out = h;
		r.frame = fr;
		r.offset = off;
		r.fetch = fe;
		r.write_back = wb;
		r.evict_handle = eh;
		r.evict_page = ep;
		r.last = lst;
		return r;
	endfunction

	logic [2:0] state_q;
	req_t req_q;
	logic [STAMP_W-1:0] stamp_q;
	logic [FRAMES-1:0] used_q, own_vld_q, dirty_q;
	logic [HW+PW-1:0] own_mem [FRAMES];
	logic [HW+PW-1:0] own_rd_q;
	logic [MAP-1:0] map_vld_q;
	logic [FW-1:0] map_fr [MAP];
	logic [CW-1:0] hpages_q [HANDLES];
	logic [HW-1:0] hdl_q;
	logic [PW-1:0] page_q;
	logic [CW-1:0] npages_q;
	logic [FW-1:0] fr_q;
	logic wb_q, fetch_q;
	logic [HW-1:0] eh_q;
	logic [PW-1:0] ep_q;
	logic [FW-1:0] map_rd_q;
	logic map_hit_q;

	scan_ctl_t scan_ctl;
	logic scan_done, st_we;
	logic [FW-1:0] victim, st_addr;
	logic [STAMP_W-1:0] st_data;

	// decode helpers
	logic free_found;
	logic [HW-1:0] free_h;
	logic [25:0] pages_w;
	logic [FW-1:0] first_unused;
	logic any_unused;
	logic [MW-1:0] slot;
	logic [PGW-1:0] pg_w;
	logic [19:0] off_w;
	logic page_last;

	always_comb begin
		free_found = 1'b0;
		free_h = '0;
		for (int h = HANDLES - 1; h >= 0; h--)
			if (hpages_q[h] == '0) begin
				free_found = 1'b1;
				free_h = HW'(h);
			end
		any_unused = 1'b0;
		first_unused = '0;
		for (int f = FRAMES - 1; f >= 0; f--)
			if (!used_q[f]) begin
				any_unused = 1'b1;
				first_unused = FW'(f);
			end
	end

	assign pages_w = ({1'b0, req_q.amount} + 26'((64'd1 << PAGE_BITS) - 1)) >> PAGE_BITS;
	assign pg_w = (PAGE_BITS >= 24) ? '0 : PGW'(req_q.byte_index >> PAGE_BITS);
	assign off_w = 20'(req_q.byte_index & ((24'd1 << PAGE_BITS) - 24'd1));
	assign slot = MW'(hdl_q * PAGES_PER_HANDLE + page_q);
	assign page_last = (CW'(page_q) + CW'(1) == npages_q);

	logic hin_ok;
	assign hin_ok = ({28'd0, req_q.handle_in} < 32'(HANDLES));

	// owner and map tables, one write and registered reads
	always_ff @(posedge clk) begin
		if (state_q == S_FILL) begin
			own_mem[fr_q] <= {hdl_q, page_q};
			map_fr[slot] <= fr_q;
		end
		map_rd_q <= map_fr[slot];
		own_rd_q <= own_mem[victim];
	end

	assign scan_ctl.start = (state_q == S_FREE) && !any_unused;
	assign st_we = (state_q == S_FILL) ||
		(state_q == S_MAP && map_hit_q);
	assign st_addr = (state_q == S_FILL) ? fr_q : map_rd_q;
	assign st_data = stamp_q;

	pfm_scan #(.FRAMES(FRAMES)) u_scan (
		.clk(clk), .arst_n(arst_n), .ctl(scan_ctl),
		.st_we(st_we), .st_addr(st_addr), .st_data(st_data),
		.done(scan_done), .victim(victim)
	);

	assign busy = (state_q != S_IDLE);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			stamp_q <= '0;
			used_q <= '0;
			own_vld_q <= '0;
			dirty_q <= '0;
			map_vld_q <= '0;
			for (int h = 0; h < HANDLES; h++)
				hpages_q[h] <= '0;
			rsp_valid <= 1'b0;
			map_hit_q <= 1'b0;
		end else begin
			rsp_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						req_q <= req;
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					wb_q <= 1'b0; eh_q <= '0; ep_q <= '0;
					if (!req_q.cmd) begin
						if (!free_found) begin
							rsp <= mk_rsp(ST_NO_HDL, '0, '0, '0, 1'b0, 1'b0, '0, '0, 1'b1);
							rsp_valid <= 1'b1;
							state_q <= S_IDLE;
						end else if (pages_w > 26'(PAGES_PER_HANDLE)) begin
							rsp <= mk_rsp(ST_TOO_BIG, '0, '0, '0, 1'b0, 1'b0, '0, '0, 1'b1);
							rsp_valid <= 1'b1;
							state_q <= S_IDLE;
						end else if (pages_w == '0) begin
							rsp <= mk_rsp(ST_OK, 4'(free_h), '0, '0, 1'b0, 1'b0, '0, '0,
								1'b1);
							rsp_valid <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							hdl_q <= free_h;
							hpages_q[free_h] <= CW'(pages_w);
							npages_q <= CW'(pages_w);
							page_q <= '0;
							fetch_q <= 1'b0;
							state_q <= S_FREE;
						end
					end else begin
						if (!hin_ok || hpages_q[HW'(req_q.handle_in)] == '0) begin
							rsp <= mk_rsp(ST_BAD_HDL, req_q.handle_in, '0, '0, 1'b0, 1'b0,
								'0, '0, 1'b1);
							rsp_valid <= 1'b1;
							state_q <= S_IDLE;
						end else if (32'(pg_w) >=
								32'(hpages_q[HW'(req_q.handle_in)])) begin
							rsp <= mk_rsp(ST_RANGE, req_q.handle_in, '0, '0, 1'b0, 1'b0,
								'0, '0, 1'b1);
							rsp_valid <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							rsp <= mk_rsp(ST_OK, req_q.handle_in, '0, '0, 1'b0, 1'b0,
								'0, '0, 1'b1);
							hdl_q <= HW'(req_q.handle_in);
							page_q <= PW'(pg_w);
							npages_q <= '0;
							fetch_q <= 1'b1;
							map_hit_q <= 1'b0;
							state_q <= S_MAP;
						end
					end
				end
				S_MAP: begin
					// the map read is registered first, then hit or claim
					if (!map_hit_q) begin
						if (map_vld_q[slot])
							map_hit_q <= 1'b1;
						else
							state_q <= S_FREE;
					end else begin
						stamp_q <= stamp_q + 1'b1;
						if (req_q.mark_dirty)
							dirty_q[map_rd_q] <= 1'b1;
						rsp.frame <= 6'(map_rd_q);
						rsp.offset <= off_w;
						rsp_valid <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_FREE: begin
					if (any_unused) begin
						used_q[first_unused] <= 1'b1;
						fr_q <= first_unused;
						wb_q <= 1'b0; eh_q <= '0; ep_q <= '0;
						state_q <= S_FILL;
					end else
						state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (scan_done) begin
						fr_q <= victim;
						state_q <= S_EVIC;
					end
				end
				S_EVIC: begin
					if (own_vld_q[fr_q]) begin
						wb_q <= dirty_q[fr_q];
						eh_q <= own_rd_q[HW+PW-1:PW];
						ep_q <= own_rd_q[PW-1:0];
						map_vld_q[MW'(own_rd_q[HW+PW-1:PW] * PAGES_PER_HANDLE +
							own_rd_q[PW-1:0])] <= 1'b0;
					end else begin
						wb_q <= 1'b0; eh_q <= '0; ep_q <= '0;
					end
					state_q <= S_FILL;
				end
				S_FILL: begin
					own_vld_q[fr_q] <= 1'b1;
					map_vld_q[slot] <= 1'b1;
					stamp_q <= stamp_q + 1'b1;
					rsp <= mk_rsp(ST_OK, 4'(hdl_q), 6'(fr_q), fetch_q ? off_w : '0,
						fetch_q, wb_q, 4'(eh_q), 4'(ep_q), fetch_q || page_last);
					if (fetch_q) begin
						// access miss: load, then restamp through the map lookup
						dirty_q[fr_q] <= 1'b0;
						state_q <= S_MAP;
					end else begin
						dirty_q[fr_q] <= 1'b1;
						rsp_valid <= 1'b1;
						if (page_last)
							state_q <= S_IDLE;
						else begin
							page_q <= page_q + 1'b1;
							state_q <= S_FREE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_no_rsp_idle: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> $past(busy)) else $error("result while idle");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("request not taken");
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.last) |-> !busy) else $error("busy after last");
endmodule

// File: rtl/pfm_scan.sv
// victim scanner: walks frames one per cycle keeping the oldest stamp
// depends on pfm_pkg; the stamp memory lives here
module pfm_scan #(
	parameter int FRAMES = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  pfm_pkg::scan_ctl_t ctl,
	input  logic st_we,
	input  logic [$clog2(FRAMES)-1:0] st_addr,
	input  logic [pfm_pkg::STAMP_W-1:0] st_data,
	output logic done,
	output logic [$clog2(FRAMES)-1:0] victim
);
	import pfm_pkg::*;
	localparam int FW = $clog2(FRAMES);

	logic [STAMP_W-1:0] stamp_mem [FRAMES];
	logic [STAMP_W-1:0] rd_q, best_stamp_q;
	logic [FW-1:0] rd_idx_q, idx_q, best_q;
	logic busy_q, rd_vld_q, last_q;

	// stamp memory, one write and one read port
	always_ff @(posedge clk) begin
		if (st_we)
			stamp_mem[st_addr] <= st_data;
		rd_q <= stamp_mem[idx_q];
		rd_idx_q <= idx_q;
	end

	// scan sequencing and running minimum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rd_vld_q <= 1'b0;
			last_q <= 1'b0;
			idx_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			rd_vld_q <= busy_q;
			last_q <= busy_q && (idx_q == FW'(FRAMES - 1));
			if (ctl.start) begin
				busy_q <= 1'b1;
				idx_q <= '0;
			end else if (busy_q) begin
				if (idx_q == FW'(FRAMES - 1))
					busy_q <= 1'b0;
				else
					idx_q <= idx_q + 1'b1;
			end
			if (rd_vld_q && last_q)
				done <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_vld_q) begin
			if (rd_idx_q == '0 || rd_q < best_stamp_q) begin
				best_stamp_q <= rd_q;
				best_q <= rd_idx_q;
			end
		end
	end

	assign victim = best_q;

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("scan done held");
	a_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start |=> busy_q) else $error("scan did not start");
endmodule
